### sv/mbp_pkg.sv
`timescale 1ns / 1ps
// Package for the MSB-first bit packer: transaction structs, operation codes
// and default sizes. Used by mbp_front, mbp_back and the top level; depends on nothing.

package mbp_pkg;

	localparam int BUF_BYTES_DEF = 4096;
	localparam int CAP_REG_W = 13;
	localparam logic [CAP_REG_W-1:0] CAP_RESET = 13'd4096;

	// Input modes as they arrive on the item channel.
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Operations after classification.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] src_byte;
		logic [2:0] first_bit;
		logic [3:0] bit_count;
		logic last_of_call;
	} item_t;

	typedef struct packed {
		logic read_bit;
		logic [3:0] dropped_in_item;
		logic [31:0] dropped_in_call;
		logic buffer_full;
		logic read_past_end;
		logic [15:0] bit_position;
	} result_t;

	// Classified command: bits holds the taken source bits left-aligned and
	// masked, count is the run length after clipping at the source LSB.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] bits;
		logic [3:0] count;
		logic last;
	} cmd_t;

endpackage

### sv/mbp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module mbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/mbp_front.sv
`timescale 1ns / 1ps
// Front end of the bit packer: accepts items, classifies them into commands
// and holds them in a two-entry queue for the back end. Uses mbp_pkg.

module mbp_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input mbp_pkg::item_t item,
	output logic cmd_valid,
	input logic cmd_pop,
	output mbp_pkg::cmd_t cmd
);

	mbp_pkg::cmd_t cls;
	mbp_pkg::cmd_t queue_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic [3:0] avail;
	logic [3:0] run_len;
	logic [7:0] aligned;
	logic push;

	always_comb begin
		// A run never reaches past the LSB of the source byte.
		avail = 4'd8 - {1'b0, item.first_bit};
		run_len = (item.bit_count > avail) ? avail : item.bit_count;
		aligned = item.src_byte << item.first_bit;
		cls.bits = aligned & ~(8'hFF >> run_len);
		cls.count = run_len;
		cls.last = item.last_of_call;
		unique case (item.mode)
			mbp_pkg::MODE_APPEND: cls.op = mbp_pkg::OP_APPEND;
			mbp_pkg::MODE_READ: cls.op = mbp_pkg::OP_READ;
			mbp_pkg::MODE_CLEAR: cls.op = mbp_pkg::OP_CLEAR;
			default: cls.op = mbp_pkg::OP_NOP;
		endcase
	end

	assign item_ready = (count_q != 2'd2);
	assign push = item_valid && item_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### sv/mbp_back.sv
`timescale 1ns / 1ps
// Back end of the bit packer: cursor, current-byte tracking, drop counters,
// the byte store and the result register. Uses mbp_pkg and mbp_ram.

module mbp_back #(
	parameter int BUF_BYTES = mbp_pkg::BUF_BYTES_DEF,
	localparam int CAP_W = $clog2(BUF_BYTES + 1),
	localparam int CUR_W = CAP_W + 3,
	localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic [CUR_W-1:0] cap_bits,
	input logic cmd_valid,
	output logic cmd_pop,
	input mbp_pkg::cmd_t cmd,
	output logic result_valid,
	input logic result_ready,
	output mbp_pkg::result_t result
);

	localparam logic PH_ISSUE = 1'b0;
	localparam logic PH_FINISH = 1'b1;

	logic phase_q;
	logic [CUR_W-1:0] cursor_q;
	logic [7:0] acc_q;
	logic written_q;
	logic [31:0] call_q;

	logic spill_we_s2;
	logic [AW-1:0] spill_addr_s2;
	logic [7:0] spill_s2;
	logic rd_s2;
	logic rd_written_s2;
	logic [2:0] rd_off_s2;
	mbp_pkg::result_t res_s2;

	logic res_valid_q;
	mbp_pkg::result_t res_q;
	mbp_pkg::result_t res_fin;

	logic cur_full;
	logic [CUR_W-1:0] room;
	logic [3:0] stored;
	logic [3:0] dropped;
	logic [2:0] off;
	logic [7:0] bits_st;
	logic [15:0] shifted;
	logic [7:0] base;
	logic [3:0] end_pos;
	logic [32:0] sum;
	logic [31:0] shown;
	logic [CAP_W-1:0] byte_idx;
	logic [AW-1:0] addr;
	logic [AW-1:0] addr_next;

	logic [CUR_W-1:0] cur_nx;
	logic [7:0] acc_nx;
	logic wr_nx;
	logic [31:0] call_nx;
	logic spill_we_nx;
	logic rd_nx;
	logic past_nx;
	logic [3:0] drop_nx;
	logic we_a;
	logic [7:0] wdata_a;
	logic ram_re;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic [7:0] ram_rdata;
	logic res_push;
	logic rbit;

	assign cmd_pop = cmd_valid && (phase_q == PH_ISSUE);
	assign res_push = (phase_q == PH_FINISH) && (!res_valid_q || result_ready);

	always_comb begin
		cur_full = (cursor_q >= cap_bits);
		room = cur_full ? '0 : (cap_bits - cursor_q);
		stored = (room < CUR_W'(cmd.count)) ? room[3:0] : cmd.count;
		dropped = cmd.count - stored;
		off = cursor_q[2:0];
		bits_st = cmd.bits & ~(8'hFF >> stored);
		shifted = {bits_st, 8'h00} >> off;
		// The byte under the cursor holds bits written since it was entered,
		// everything at or past the cursor reads as zero.
		base = written_q ? acc_q : 8'h00;
		end_pos = {1'b0, off} + stored;
		sum = {1'b0, call_q} + 33'(dropped);
		byte_idx = cursor_q[CUR_W-1:3];
		addr = AW'(byte_idx);
		addr_next = AW'(byte_idx + CAP_W'(1));

		cur_nx = cursor_q;
		acc_nx = acc_q;
		wr_nx = written_q;
		call_nx = call_q;
		shown = call_q;
		spill_we_nx = 1'b0;
		rd_nx = 1'b0;
		past_nx = 1'b0;
		drop_nx = 4'd0;
		we_a = 1'b0;
		wdata_a = base | shifted[15:8];
		ram_re = 1'b0;

		case (cmd.op)
			mbp_pkg::OP_APPEND: begin
				cur_nx = cursor_q + CUR_W'(stored);
				drop_nx = dropped;
				shown = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				call_nx = cmd.last ? 32'd0 : shown;
				if (stored != 4'd0) begin
					we_a = 1'b1;
					if (end_pos > 4'd8) begin
						acc_nx = shifted[7:0];
						wr_nx = 1'b1;
						spill_we_nx = 1'b1;
					end else if (end_pos == 4'd8) begin
						acc_nx = 8'h00;
						wr_nx = 1'b0;
					end else begin
						acc_nx = wdata_a;
						wr_nx = 1'b1;
					end
				end
			end
			mbp_pkg::OP_READ: begin
				if (cur_full) begin
					past_nx = 1'b1;
				end else begin
					ram_re = 1'b1;
					rd_nx = 1'b1;
					cur_nx = cursor_q + CUR_W'(1);
					if (off == 3'd7) begin
						acc_nx = 8'h00;
						wr_nx = 1'b0;
					end
				end
			end
			mbp_pkg::OP_CLEAR: begin
				// Bytes past the cursor are never read back before being
				// written again, so the store itself needs no sweep.
				cur_nx = '0;
				acc_nx = 8'h00;
				wr_nx = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign ram_we = (cmd_pop && we_a) || ((phase_q == PH_FINISH) && spill_we_s2);
	assign ram_waddr = (phase_q == PH_FINISH) ? spill_addr_s2 : addr;
	assign ram_wdata = (phase_q == PH_FINISH) ? spill_s2 : wdata_a;

	mbp_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(cmd_pop && ram_re),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	assign rbit = rd_s2 && rd_written_s2 && ram_rdata[3'd7 - rd_off_s2];

	always_comb begin
		res_fin = res_s2;
		res_fin.read_bit = rbit;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			spill_addr_s2 <= addr_next;
			spill_s2 <= shifted[7:0];
			rd_written_s2 <= written_q;
			rd_off_s2 <= off;
			res_s2.read_bit <= 1'b0;
			res_s2.dropped_in_item <= drop_nx;
			res_s2.dropped_in_call <= shown;
			res_s2.buffer_full <= (cur_nx >= cap_bits);
			res_s2.read_past_end <= past_nx;
			res_s2.bit_position <= 16'(cur_nx);
		end
		if (res_push) begin
			res_q <= res_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ISSUE;
			cursor_q <= '0;
			acc_q <= 8'h00;
			written_q <= 1'b0;
			call_q <= 32'd0;
			spill_we_s2 <= 1'b0;
			rd_s2 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				phase_q <= PH_FINISH;
				cursor_q <= cur_nx;
				acc_q <= acc_nx;
				written_q <= wr_nx;
				call_q <= call_nx;
				spill_we_s2 <= spill_we_nx;
				rd_s2 <= rd_nx;
			end else if (res_push) begin
				phase_q <= PH_ISSUE;
			end
			if (res_push) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_acc_zero_when_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		!written_q |-> (acc_q == 8'h00))
		else $error("current byte holds bits while marked unwritten");

	a_cursor_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(BUF_BYTES * 8))
		else $error("cursor ran past the end of the store");

	a_issue_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (phase_q == PH_FINISH))
		else $error("command issued without entering the finish phase");

	a_no_pop_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FINISH) |-> !cmd_pop)
		else $error("command taken while the previous one is unfinished");

	a_spill_only_after_append: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FINISH) && spill_we_s2 |-> !rd_s2)
		else $error("spill write scheduled for a read command");

endmodule

### sv/msb_first_bit_packer.sv
`timescale 1ns / 1ps
// Top level of the MSB-first bit packer: capacity register, front end and
// back end. Uses mbp_pkg, mbp_front, mbp_back (and through it mbp_ram).

// The packer keeps a byte store of BUF_BYTES bytes and one bit cursor. Each item
// passes an issue and a finish phase in the back end, set by the single write
// port of the store: an append writes the byte under the cursor in the issue
// phase and the byte it spills into in the finish phase, and a read uses the
// finish phase for the registered store read. The back end takes no new item
// before the last one has finished; a two-entry queue in front and an output
// register behind let either side stall on its own, and a result passes the
// queue, both phases and the output register. The store is never swept: the back
// end tracks which part of the byte under the cursor has been written since it
// was entered, so reset and clear take effect at once. The user must see that
// capacity is written through the cfg channel only while no transaction is in
// flight; the block does not enforce it. Values above BUF_BYTES act as BUF_BYTES.

module msb_first_bit_packer #(
	parameter int BUF_BYTES = mbp_pkg::BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input mbp_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output mbp_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [mbp_pkg::CAP_REG_W-1:0] cfg_data
);

	localparam int CAP_W = $clog2(BUF_BYTES + 1);
	localparam int CUR_W = CAP_W + 3;

	logic [mbp_pkg::CAP_REG_W-1:0] capacity_q;
	logic [CAP_W-1:0] cap_bytes;
	logic [CUR_W-1:0] cap_bits;
	logic cmd_valid;
	logic cmd_pop;
	mbp_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= mbp_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	assign cap_bytes = (32'(capacity_q) > 32'(BUF_BYTES)) ? CAP_W'(BUF_BYTES)
		: CAP_W'(capacity_q);
	assign cap_bits = {cap_bytes, 3'b000};

	mbp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	mbp_back #(
		.BUF_BYTES(BUF_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cap_bits(cap_bits),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
